FILE: rtl/pwl_pkg.sv
// ----------------------------------------------------------------------------
// pwl_pkg
// Types and constants shared by the piecewise linear interpolator.
// ----------------------------------------------------------------------------
package pwl_pkg;

  localparam int unsigned MaxPointsDef = 64;

  localparam logic [1:0] CMD_CLEAR = 2'd0;
  localparam logic [1:0] CMD_LOAD  = 2'd1;
  localparam logic [1:0] CMD_QUERY = 2'd2;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_EMPTY = 2'd1;
  localparam logic [1:0] ST_ORDER = 2'd2;
  localparam logic [1:0] ST_FULL  = 2'd3;

  typedef struct packed {
    logic [1:0]         command;
    logic [15:0]        coord_x;
    logic signed [15:0] coord_y;
  } pwl_in_t;

  typedef struct packed {
    logic signed [15:0] value_y;
    logic [1:0]         status;
  } pwl_out_t;

endpackage

FILE: rtl/pwl_front.sv
// ----------------------------------------------------------------------------
// pwl_front
// Accepts commands and holds them in a two-word queue for the back part.
// ----------------------------------------------------------------------------
module pwl_front (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  pwl_pkg::pwl_in_t word_i,
  output logic            full_o,
  input  logic            pop_i,
  output logic            avail_o,
  output pwl_pkg::pwl_in_t word_o
);
  import pwl_pkg::*;

  pwl_in_t    slot_q [2];
  logic       wr_q, rd_q;
  logic [1:0] cnt_q;

  assign full_o  = (cnt_q == 2'd2);
  assign avail_o = (cnt_q != 2'd0);
  assign word_o  = slot_q[rd_q];

  always_ff @(posedge clk_i) begin
    if (push_i) slot_q[wr_q] <= word_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q <= 1'b0; rd_q <= 1'b0; cnt_q <= 2'd0;
    end else begin
      if (push_i) wr_q <= ~wr_q;
      if (pop_i) rd_q <= ~rd_q;
      cnt_q <= cnt_q + {1'b0, push_i} - {1'b0, pop_i};
    end
  end

endmodule

FILE: rtl/pwl_back.sv
// ----------------------------------------------------------------------------
// pwl_back
// Executes commands: table update, binary search and serial division.
// ----------------------------------------------------------------------------
module pwl_back #(
  parameter int unsigned MaxPoints = pwl_pkg::MaxPointsDef
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             avail_i,
  input  pwl_pkg::pwl_in_t word_i,
  output logic             pop_o,
  output logic             valid_o,
  output pwl_pkg::pwl_out_t res_o
);
  import pwl_pkg::*;

  localparam int unsigned AW = (MaxPoints > 1) ? $clog2(MaxPoints) : 1;
  localparam int unsigned CW = $clog2(MaxPoints + 1);

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_LAST  = 4'd1;  // read last point
  localparam logic [3:0] S_LASTW = 4'd2;
  localparam logic [3:0] S_FIRST = 4'd3;
  localparam logic [3:0] S_FIRSTW= 4'd4;
  localparam logic [3:0] S_SRCH  = 4'd5;
  localparam logic [3:0] S_SRCHW = 4'd6;
  localparam logic [3:0] S_UP    = 4'd7;
  localparam logic [3:0] S_LOW   = 4'd8;
  localparam logic [3:0] S_LOWW  = 4'd9;
  localparam logic [3:0] S_MUL   = 4'd10;
  localparam logic [3:0] S_DIV   = 4'd11;
  localparam logic [3:0] S_DONE  = 4'd12;
  localparam logic [3:0] S_ADD   = 4'd13;

  logic [15:0]        mx_q [MaxPoints];
  logic signed [15:0] my_q [MaxPoints];
  logic [15:0]        rx_q;
  logic signed [15:0] ry_q;
  logic [AW-1:0]      raddr;
  logic               we;
  logic [AW-1:0]      waddr;
  logic [15:0]        wx;
  logic signed [15:0] wy;

  logic [3:0]         st_q;
  pwl_in_t            cmd_q;
  logic [CW-1:0]      cnt_q;
  logic [CW-1:0]      lo_q, hi_q;
  logic [15:0]        ux_q, lx_q;
  logic signed [15:0] uy_q, ly_q;
  logic               neg_q;
  logic [15:0]        rem_q;   // partial remainder
  logic [31:0]        num_q;
  logic [4:0]         step_q;
  logic [15:0]        den_q;
  logic               valid_q;
  pwl_out_t           res_q;

  logic [CW-1:0] mid;
  logic [CW-1:0] last;
  assign last = cnt_q - 1'b1;
  assign mid  = lo_q + ((hi_q - lo_q) >> 1);

  always_ff @(posedge clk_i) begin
    if (we) begin
      mx_q[waddr] <= wx;
      my_q[waddr] <= wy;
    end
    rx_q <= mx_q[raddr];
    ry_q <= my_q[raddr];
  end

  logic signed [16:0] ysum;
  logic signed [16:0] dy;
  logic [16:0]        ady;
  logic [16:0]        dq;
  logic [16:0]        trial;
  assign ysum  = 17'(ry_q) + 17'(cmd_q.coord_y);
  assign dy    = 17'(uy_q) - 17'(ly_q);
  assign ady   = dy[16] ? 17'(-dy) : dy;
  assign dq    = 17'(cmd_q.coord_x) - 17'(lx_q);
  assign trial = {rem_q, num_q[31]} - {1'b0, den_q};

  always_comb begin
    raddr = '0;
    case (st_q)
      S_IDLE:  raddr = AW'(last);
      S_LAST:  raddr = AW'(last);
      S_FIRST: raddr = '0;
      S_SRCH:  raddr = AW'(mid);
      S_UP:    raddr = AW'(lo_q);
      S_LOW:   raddr = AW'(lo_q - 1'b1);
      default: raddr = AW'(last);
    endcase
  end

  always_comb begin
    we = 1'b0; waddr = AW'(last); wx = cmd_q.coord_x; wy = cmd_q.coord_y;
    if (st_q == S_LASTW && cmd_q.command == CMD_LOAD) begin
      if (cnt_q != '0 && cmd_q.coord_x == rx_q) begin
        we = 1'b1; wy = ysum[16:1];
      end else if (!(cnt_q != '0 && cmd_q.coord_x < rx_q) &&
                   cnt_q < CW'(MaxPoints)) begin
        we = 1'b1; waddr = AW'(cnt_q);
      end
    end
  end

  assign pop_o   = (st_q == S_IDLE) && avail_i;
  assign valid_o = valid_q;
  assign res_o   = res_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= S_IDLE; cnt_q <= '0; valid_q <= 1'b0;
    end else begin
      valid_q <= 1'b0;
      case (st_q)
        S_IDLE: if (avail_i) begin
          cmd_q <= word_i;
          st_q  <= S_LAST;
        end
        S_LAST: st_q <= S_LASTW;
        S_LASTW: begin
          res_q <= '{value_y: '0, status: ST_OK};
          st_q  <= S_DONE;
          case (cmd_q.command)
            CMD_CLEAR: cnt_q <= '0;
            CMD_LOAD: begin
              if (cnt_q != '0 && cmd_q.coord_x == rx_q) begin
              end else if (cnt_q != '0 && cmd_q.coord_x < rx_q) begin
                res_q.status <= ST_ORDER;
              end else if (cnt_q >= CW'(MaxPoints)) begin
                res_q.status <= ST_FULL;
              end else begin
                cnt_q <= cnt_q + 1'b1;
              end
            end
            CMD_QUERY: begin
              if (cnt_q == '0) res_q.status <= ST_EMPTY;
              else if (cmd_q.coord_x >= rx_q) res_q.value_y <= ry_q;
              else st_q <= S_FIRST;
            end
            default: ;
          endcase
        end
        S_FIRST: st_q <= S_FIRSTW;
        S_FIRSTW: begin
          if (cmd_q.coord_x <= rx_q) begin
            res_q.value_y <= ry_q;
            st_q <= S_DONE;
          end else begin
            lo_q <= CW'(1); hi_q <= last;
            st_q <= S_SRCH;
          end
        end
        S_SRCH: st_q <= (lo_q < hi_q) ? S_SRCHW : S_UP;
        S_SRCHW: begin
          if (rx_q < cmd_q.coord_x) lo_q <= mid + 1'b1;
          else hi_q <= mid;
          st_q <= S_SRCH;
        end
        S_UP: st_q <= S_LOW;
        S_LOW: begin
          ux_q <= rx_q; uy_q <= ry_q;
          st_q <= S_LOWW;
        end
        S_LOWW: begin
          lx_q <= rx_q; ly_q <= ry_q;
          st_q <= S_MUL;
        end
        S_MUL: begin
          num_q  <= dq[15:0] * ady[15:0] + (ady[16] ? {dq[15:0], 16'd0} : 32'd0);
          den_q  <= ux_q - lx_q;
          neg_q  <= dy[16];
          rem_q  <= '0;
          step_q <= '0;
          st_q   <= S_DIV;
        end
        S_DIV: begin
          // restoring step, one quotient bit per cycle
          if (!trial[16]) rem_q <= trial[15:0];
          else rem_q <= {rem_q[14:0], num_q[31]};
          num_q  <= {num_q[30:0], ~trial[16]};
          step_q <= step_q + 1'b1;
          if (step_q == 5'd31) st_q <= S_ADD;
        end
        S_ADD: begin
          res_q.value_y <= neg_q ? ly_q - num_q[15:0] : ly_q + num_q[15:0];
          st_q <= S_DONE;
        end
        S_DONE: begin
          valid_q <= 1'b1;
          st_q    <= S_IDLE;
        end
        default: st_q <= S_IDLE;
      endcase
    end
  end

endmodule

FILE: rtl/piecewise_linear_table_interp.sv
// ----------------------------------------------------------------------------
// piecewise_linear_table_interp
// Breakpoint table with clamped piecewise linear interpolation queries.
// ----------------------------------------------------------------------------
// Commands run one at a time in the back part; a query can take longer than a
// clear or load, set by the binary search over the table memory and the
// 32-step restoring divider, and is shorter when it clamps. The two-word
// queue hides short bursts. Reset empties the table and the command queue;
// the receiver cannot stall.
module piecewise_linear_table_interp #(
  parameter int unsigned MaxPoints = pwl_pkg::MaxPointsDef
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start,
  output logic              busy,
  input  pwl_pkg::pwl_in_t  in_i,
  output logic              strobe,
  output pwl_pkg::pwl_out_t out_o
);
  import pwl_pkg::*;

  logic    full, avail, pop;
  pwl_in_t qword;

  assign busy = full;

  pwl_front u_front (
    .clk_i, .rst_ni,
    .push_i(start && !full), .word_i(in_i), .full_o(full),
    .pop_i(pop), .avail_o(avail), .word_o(qword)
  );

  pwl_back #(.MaxPoints(MaxPoints)) u_back (
    .clk_i, .rst_ni,
    .avail_i(avail), .word_i(qword), .pop_o(pop),
    .valid_o(strobe), .res_o(out_o)
  );

  a_pop_avail: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop |-> avail) else $error("pop from empty queue");
  a_err_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    strobe && out_o.status != ST_OK |-> out_o.value_y == '0)
    else $error("error result carries value");
  a_strobe_pulse: assert property (@(posedge clk_i) disable iff (!rst_ni)
    strobe |=> !strobe) else $error("strobe longer than one cycle");

endmodule
